### hdl/clipped_surface_blit_core_defines.svh
// Assertion macros shared by the clipped surface blit core.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef CLIPPED_SURFACE_BLIT_CORE_DEFINES_SVH
`define CLIPPED_SURFACE_BLIT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/csb_pkg.sv
// Package for the clipped surface blit core: widths, register indexes,
// configuration and stage types, and the source size helper. No dependencies.
`default_nettype none

package csb_pkg;

   // Field and datapath widths.
   localparam int PIXEL_W    = 32;
   localparam int ADDR_W     = 20;
   localparam int SIZE_W     = 13;
   localparam int COUNT_W    = 12;
   localparam int CLIP_W     = 15;
   localparam int POS_W      = 16;
   localparam int TGT_W      = POS_W + 1;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   // Framebuffer defaults.
   localparam int FB_WIDTH_DEF  = 1024;
   localparam int FB_HEIGHT_DEF = 768;

   // Largest source dimension.
   localparam logic [SIZE_W-1:0] MAX_SIZE = 13'd4096;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEST_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEST_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_X     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_Y     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_W     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_H     = 3'd7;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic        [SIZE_W-1:0] src_width;
      logic        [SIZE_W-1:0] src_height;
      logic signed [POS_W-1:0]  dest_x;
      logic signed [POS_W-1:0]  dest_y;
      logic signed [POS_W-1:0]  clip_x;
      logic signed [POS_W-1:0]  clip_y;
      logic        [CLIP_W-1:0] clip_w;
      logic        [CLIP_W-1:0] clip_h;
   } cfg_type;

   // Word held between the scan stage and the clip stage.
   typedef struct packed {
      logic        [PIXEL_W-1:0] pixel;
      logic signed [TGT_W-1:0]   tx;
      logic signed [TGT_W-1:0]   ty;
      logic                      last;
   } stage_type;

   // Index of the last column or row: zero acts as one, sizes above the
   // maximum act as the maximum.
   function automatic logic [COUNT_W-1:0] last_index(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] clamped;
      begin
         if (size == '0) begin
            clamped = 13'd1;
         end else if (size > MAX_SIZE) begin
            clamped = MAX_SIZE;
         end else begin
            clamped = size;
         end
         last_index = COUNT_W'(clamped - 13'd1);
      end
   endfunction

endpackage

`default_nettype wire

### hdl/clipped_surface_blit_core.sv
// Top level of the clipped surface blit core: configuration registers, scan
// stage and clip stage. Depends on csb_pkg, csb_csr, csb_scan and csb_clip.
`default_nettype none

// The core takes one 32-bit source pixel per word in raster order and returns
// one result word for each: a write enable, the framebuffer address (row times
// the framebuffer width plus column) and the pixel, with blit_done marking the
// last pixel of the surface, after which the raster counters start over. It
// sustains one pixel per clock while the result side takes its words: each
// pixel passes through the input register of the scan stage and then the
// result register of the clip stage before its result is presented. Program
// the registers only while no pixel is in flight; a source size made smaller
// mid-blit ends the row or the blit early.

module clipped_surface_blit_core
   import csb_pkg::*;
#(
   parameter int FB_WIDTH  = FB_WIDTH_DEF,
   parameter int FB_HEIGHT = FB_HEIGHT_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [PIXEL_W-1:0]    req_src_pixel,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_write_enable,
   output logic [ADDR_W-1:0]          rsp_fb_address,
   output logic [PIXEL_W-1:0]         rsp_fb_pixel,
   output logic                       rsp_blit_done
);

   cfg_type   cfg;
   stage_type stg;
   logic      stg_valid;
   logic      stg_take;

   // Configuration registers.
   csb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Raster counters and input register.
   csb_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_src_pixel (req_src_pixel),
      .stg_take      (stg_take),
      .stg_valid     (stg_valid),
      .stg           (stg)
   );

   // Clip tests, address and result register.
   csb_clip #(
      .FB_WIDTH  (FB_WIDTH),
      .FB_HEIGHT (FB_HEIGHT)
   ) u_clip (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .stg_valid        (stg_valid),
      .stg              (stg),
      .stg_take         (stg_take),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_enable (rsp_write_enable),
      .rsp_fb_address   (rsp_fb_address),
      .rsp_fb_pixel     (rsp_fb_pixel),
      .rsp_blit_done    (rsp_blit_done)
   );

endmodule

`default_nettype wire

### hdl/csb_csr.sv
// Configuration registers of the clipped surface blit core.
// Depends on csb_pkg for register indexes and the configuration type.
`default_nettype none

module csb_csr
   import csb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode a write into the addressed register; every index is a register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SRC_WIDTH:  cfg_in.src_width  = csr_wdata[SIZE_W-1:0];
            REG_SRC_HEIGHT: cfg_in.src_height = csr_wdata[SIZE_W-1:0];
            REG_DEST_X:     cfg_in.dest_x     = csr_wdata;
            REG_DEST_Y:     cfg_in.dest_y     = csr_wdata;
            REG_CLIP_X:     cfg_in.clip_x     = csr_wdata;
            REG_CLIP_Y:     cfg_in.clip_y     = csr_wdata;
            REG_CLIP_W:     cfg_in.clip_w     = csr_wdata[CLIP_W-1:0];
            REG_CLIP_H:     cfg_in.clip_h     = csr_wdata[CLIP_W-1:0];
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   // Registers with their reset values: a one by one surface, empty clip.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= 13'd1;
         cfg_ff.src_height <= 13'd1;
         cfg_ff.dest_x     <= '0;
         cfg_ff.dest_y     <= '0;
         cfg_ff.clip_x     <= '0;
         cfg_ff.clip_y     <= '0;
         cfg_ff.clip_w     <= '0;
         cfg_ff.clip_h     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hdl/csb_scan.sv
// Scan stage: raster counters and the input register that holds the pixel
// with its target position. Depends on csb_pkg and the assertion macros.
`default_nettype none
`include "clipped_surface_blit_core_defines.svh"

module csb_scan
   import csb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  cfg_type                 cfg,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [PIXEL_W-1:0] req_src_pixel,
   input  wire logic               stg_take,
   output logic                    stg_valid,
   output stage_type               stg
);

   logic [COUNT_W-1:0] col_ff, col_in;
   logic [COUNT_W-1:0] row_ff, row_in;
   logic               stg_valid_ff, stg_valid_in;
   stage_type          stg_ff, stg_in;
   logic               accept;
   logic               end_row;
   logic               end_blit;

   // The stage frees up whenever the clip stage takes its word.
   assign req_ready = !stg_valid_ff || stg_take;
   assign accept    = req_valid && req_ready;

   // End of row and end of blit; counters beyond the last index also end.
   assign end_row  = col_ff >= last_index(cfg.src_width);
   assign end_blit = end_row && (row_ff >= last_index(cfg.src_height));

   // Counter update on each accepted word.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (end_blit) begin
            col_in = '0;
            row_in = '0;
         end else if (end_row) begin
            col_in = '0;
            row_in = row_ff + 12'd1;
         end else begin
            col_in = col_ff + 12'd1;
         end
      end
   end

   // Target position is the destination offset plus the source position.
   always_comb begin
      stg_in.pixel = req_src_pixel;
      stg_in.tx    = {cfg.dest_x[POS_W-1], cfg.dest_x} + TGT_W'(col_ff);
      stg_in.ty    = {cfg.dest_y[POS_W-1], cfg.dest_y} + TGT_W'(row_ff);
      stg_in.last  = end_blit;
   end

   assign stg_valid_in = accept || (stg_valid_ff && !stg_take);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         stg_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         stg_valid_ff <= stg_valid_in;
      end
   end

   // Stage payload loads only on an accepted word.
   always_ff @(posedge clock) begin
      if (accept) begin
         stg_ff <= stg_in;
      end
   end

   assign stg_valid = stg_valid_ff;
   assign stg       = stg_ff;

   `CSB_ASSERT_NEXT(a_blit_wraps, clock, reset, accept && end_blit,
      col_ff == '0 && row_ff == '0, "counters did not return to zero after the last pixel")
   `CSB_ASSERT_NEXT(a_col_steps, clock, reset, accept && !end_row,
      col_ff == $past(col_ff) + 12'd1 && row_ff == $past(row_ff), "column counter did not step")
   `CSB_ASSERT_NEXT(a_stage_holds, clock, reset, stg_valid_ff && !stg_take,
      stg_valid_ff && $stable(stg_ff), "stalled stage word changed")

endmodule

`default_nettype wire

### hdl/csb_clip.sv
// Clip stage: framebuffer and clip rectangle tests, address formation and
// the result register. Depends on csb_pkg and the assertion macros.
`default_nettype none
`include "clipped_surface_blit_core_defines.svh"

module csb_clip
   import csb_pkg::*;
#(
   parameter int FB_WIDTH  = FB_WIDTH_DEF,
   parameter int FB_HEIGHT = FB_HEIGHT_DEF
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  cfg_type                  cfg,
   input  wire logic                stg_valid,
   input  stage_type                stg,
   output logic                     stg_take,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_write_enable,
   output logic [ADDR_W-1:0]        rsp_fb_address,
   output logic [PIXEL_W-1:0]       rsp_fb_pixel,
   output logic                     rsp_blit_done
);

   localparam int PROD_W = 2 * COUNT_W + 1;
   localparam logic signed [TGT_W-1:0] FbWidthS  = TGT_W'(FB_WIDTH);
   localparam logic signed [TGT_W-1:0] FbHeightS = TGT_W'(FB_HEIGHT);
   localparam logic [PROD_W-1:0]       FbStride  = PROD_W'(FB_WIDTH);

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      we_ff, we_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic [PIXEL_W-1:0]        pixel_ff;
   logic                      done_ff;
   logic signed [TGT_W:0]     tx_w, ty_w;
   logic signed [TGT_W:0]     clip_x0, clip_y0, clip_x1, clip_y1;
   logic                      in_fb, in_clip;
   logic [PROD_W-1:0]         addr_full;
   logic                      load;

   // The result register takes a word when it is empty or being read.
   assign stg_take = !rsp_valid_ff || rsp_ready;
   assign load     = stg_valid && stg_take;

   // Framebuffer bounds.
   assign in_fb = !stg.tx[TGT_W-1] && (stg.tx < FbWidthS) &&
                  !stg.ty[TGT_W-1] && (stg.ty < FbHeightS);

   // Clip rectangle bounds, one bit wider so the far edge cannot overflow.
   assign tx_w    = {stg.tx[TGT_W-1], stg.tx};
   assign ty_w    = {stg.ty[TGT_W-1], stg.ty};
   assign clip_x0 = (TGT_W+1)'(cfg.clip_x);
   assign clip_y0 = (TGT_W+1)'(cfg.clip_y);
   assign clip_x1 = clip_x0 + $signed({3'b000, cfg.clip_w});
   assign clip_y1 = clip_y0 + $signed({3'b000, cfg.clip_h});
   assign in_clip = (tx_w >= clip_x0) && (tx_w < clip_x1) &&
                    (ty_w >= clip_y0) && (ty_w < clip_y1);

   // Row times stride plus column; coordinates fit the count width when written.
   assign addr_full = PROD_W'(stg.ty[COUNT_W-1:0]) * FbStride
                    + PROD_W'(stg.tx[COUNT_W-1:0]);

   assign we_in        = in_fb && in_clip;
   assign addr_in      = we_in ? addr_full[ADDR_W-1:0] : '0;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   // Result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         we_ff    <= we_in;
         addr_ff  <= addr_in;
         pixel_ff <= stg.pixel;
         done_ff  <= stg.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_fb_address   = addr_ff;
   assign rsp_fb_pixel     = pixel_ff;
   assign rsp_blit_done    = done_ff;

   `CSB_ASSERT_SAME(a_idle_addr_zero, clock, reset, rsp_valid_ff && !we_ff,
      addr_ff == '0, "address not zero on a suppressed write")
   `CSB_ASSERT_NEXT(a_load_pixel, clock, reset, load,
      rsp_valid_ff && pixel_ff == $past(stg.pixel), "result register missed a word")
   `CSB_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid_ff && !rsp_ready,
      rsp_valid_ff && $stable({we_ff, addr_ff, pixel_ff, done_ff}), "stalled result word changed")

endmodule

`default_nettype wire
